/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker of the convolution core.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rgbc_pkg.sv */
// Shared types and constants for the RGB 3x3 convolution core.
// No dependencies; imported by the core, the line store, the tap cell and the testbench.
`timescale 1ns / 1ps
package rgbc_pkg;

	localparam int PIX_W  = 24;
	localparam int CH_W   = 8;
	localparam int COEF_W = 8;
	localparam int ACC_W  = 18;
	localparam int SUM_W  = 21;
	localparam int TAPS   = 9;
	localparam int IDX_W  = 3;
	localparam logic [CH_W-1:0] CLAMP_MAX = 8'd255;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
	localparam logic [IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
	localparam logic [IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [TAPS-1:0][PIX_W-1:0] window_t;
	typedef logic [2:0][ACC_W-1:0] acc3_t;

	// Control carried along the tap chain
	typedef struct packed {
		logic valid;
		logic interior;
		logic frame_end;
	} cell_ctl_t;

endpackage

/* rtl/rgb_3x3_convolution_abs_clamp_core.sv */
// RGB 3x3 convolution with absolute value and clamp to 255.
// Input tdata: red[7:0], green[15:8], blue[23:16]; tuser[0]: 0 pixel, 1 flush.
// Output tdata: same channel order; tlast marks the result of the frame's last pixel.
// Configuration: cfg_wr_en/cfg_index/cfg_data, index 0 width, 1 height, 2..4 kernel
// rows top to bottom (byte 0 left, byte 1 center, byte 2 right, signed eighths).
// Write configuration only while the core is idle.
// Pixels arrive in raster order, one per cycle at full rate while s_tready is high.
// The result for a pixel leaves once its lower-right neighbour has been accepted;
// flush transactions at the start of a frame drain the remaining width+1 results.
// Path from acceptance to m_tvalid: line-memory read into the input stage at the
// accepting edge, nine tap cells, one output register.
// Throughput: one transaction per cycle unless stalled, set by one read and one write
// per cycle on the line memories and the nine-cell tap chain, which advance together.
// Reset clears the counters, the window (to zero) and all valid flags; the line
// memories are not cleared and come up unknown, which only border results see.
// When the receiver stalls with a result waiting in the output register, the
// chain holds only if its last cell carries a result; otherwise input goes on.
// Depends on rgbc_pkg, rgbc_line_store and rgbc_tap_cell.
`timescale 1ns / 1ps
module rgb_3x3_convolution_abs_clamp_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // red_in, green_in, blue_in
	input  logic [0:0]                    s_tuser,   // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // red_out, green_out, blue_out
	output logic                          m_tlast,
	input  logic                          cfg_wr_en,
	input  logic [rgbc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [23:0]                   cfg_data
);
	import rgbc_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = AW + 1;
	localparam int PW = $clog2(MAX_WIDTH + 2) + 1;

	// Configuration registers
	logic [10:0]      width_q;
	logic [15:0]      height_q;
	logic [2:0][23:0] kernel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd3;
			height_q <= 16'd3;
			kernel_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q     <= cfg_data[10:0];
				REG_IMAGE_HEIGHT: height_q    <= cfg_data[15:0];
				REG_KERNEL_TOP:   kernel_q[0] <= cfg_data;
				REG_KERNEL_MID:   kernel_q[1] <= cfg_data;
				REG_KERNEL_BOT:   kernel_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective frame size
	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;

	always_comb begin
		if (width_q == 11'd0)
			w_eff = WW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	// Stall control
	logic      adv;
	logic      acc_in;
	logic      is_flush;
	cell_ctl_t ctl_last;

	assign adv      = !(m_tvalid && !m_tready && ctl_last.valid);
	assign s_tready = adv;
	assign acc_in   = s_tvalid && adv;
	assign is_flush = s_tuser[0];

	// Position counters and pending count
	logic [AW-1:0] in_col_q, out_col_q;
	logic [15:0]   in_row_q, out_row_q;
	logic [PW-1:0] pending_q;
	logic          emit0;
	logic          interior0;
	logic          fend0;
	logic          in_col_wrap, out_col_wrap, in_row_wrap, out_row_wrap;

	assign in_col_wrap  = ({1'b0, in_col_q} + WW'(1)) >= w_eff;
	assign out_col_wrap = ({1'b0, out_col_q} + WW'(1)) >= w_eff;
	assign in_row_wrap  = ({1'b0, in_row_q} + 17'd1) >= {1'b0, h_eff};
	assign out_row_wrap = ({1'b0, out_row_q} + 17'd1) >= {1'b0, h_eff};

	always_comb begin
		if (is_flush)
			emit0 = (pending_q != '0) && (in_row_q == 16'd0) && (in_col_q == '0);
		else
			emit0 = pending_q >= (PW'(w_eff) + PW'(1));
		interior0 = (out_row_q != 16'd0) && !out_row_wrap &&
			(out_col_q != '0) && !out_col_wrap;
		fend0 = out_row_wrap && out_col_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (acc_in) begin
			if (!is_flush) begin
				if (in_col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_wrap ? 16'd0 : in_row_q + 16'd1;
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
				if (!emit0)
					pending_q <= pending_q + PW'(1);
			end else if (emit0) begin
				pending_q <= pending_q - PW'(1);
			end
			if (emit0) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_wrap ? 16'd0 : out_row_q + 16'd1;
				end else begin
					out_col_q <= out_col_q + AW'(1);
				end
			end
		end
	end

	// Stage 1: line memory read and bypass
	logic          valid_s1, pix_s1, emit_s1, interior_s1, fend_s1, byp_s1;
	pix_t          px_s1, bmid_s1, btop_s1;
	logic [AW-1:0] col_s1;
	pix_t          rd_prev, rd_second;
	pix_t          mid_s1, top_s1;
	logic          wr_s1;

	assign mid_s1 = byp_s1 ? bmid_s1 : rd_prev;
	assign top_s1 = byp_s1 ? btop_s1 : rd_second;
	assign wr_s1  = adv && valid_s1 && pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1      <= !is_flush;
			emit_s1     <= emit0;
			interior_s1 <= interior0;
			fend_s1     <= fend0;
			px_s1       <= s_tdata;
			col_s1      <= in_col_q;
			byp_s1      <= valid_s1 && pix_s1 && (col_s1 == in_col_q);
			bmid_s1     <= px_s1;
			btop_s1     <= mid_s1;
		end
	end

	rgbc_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW(AW)
	) u_lines (
		.clk(clk),
		.rd_en(acc_in && !is_flush),
		.rd_addr(in_col_q),
		.wr_en(wr_s1),
		.wr_addr(col_s1),
		.wr_prev(px_s1),
		.wr_second(mid_s1),
		.rd_prev(rd_prev),
		.rd_second(rd_second)
	);

	// Sliding 3x3 window
	window_t win_q, win_nx, win_cur;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r*3]   = win_q[r*3+1];
			win_nx[r*3+1] = win_q[r*3+2];
		end
		win_nx[2] = top_s1;
		win_nx[5] = mid_s1;
		win_nx[8] = px_s1;
		win_cur   = pix_s1 ? win_nx : win_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (wr_s1) begin
			win_q <= win_nx;
		end
	end

	// Tap chain
	cell_ctl_t ctl_c [TAPS+1];
	window_t   win_c [TAPS+1];
	acc3_t     acc_c [TAPS+1];

	assign ctl_c[0].valid     = valid_s1 && emit_s1;
	assign ctl_c[0].interior  = interior_s1;
	assign ctl_c[0].frame_end = fend_s1;
	assign win_c[0]           = win_cur;
	assign acc_c[0]           = '0;

	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		rgbc_tap_cell #(
			.TAP(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.coef(signed'(kernel_q[k/3][COEF_W*(k%3) +: COEF_W])),
			.ctl_in(ctl_c[k]),
			.win_in(win_c[k]),
			.acc_in(acc_c[k]),
			.ctl_out(ctl_c[k+1]),
			.win_out(win_c[k+1]),
			.acc_out(acc_c[k+1])
		);
	end

	assign ctl_last = ctl_c[TAPS];

	// Absolute value, clamp and border mask
	logic [23:0] res;

	always_comb begin
		logic signed [ACC_W-1:0] a;
		logic [ACC_W-1:0]        mag;
		for (int ch = 0; ch < 3; ch++) begin
			a   = signed'(acc_c[TAPS][ch]);
			mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
			if (!ctl_last.interior)
				res[CH_W*ch +: CH_W] = '0;
			else if (mag > ACC_W'(CLAMP_MAX))
				res[CH_W*ch +: CH_W] = CLAMP_MAX;
			else
				res[CH_W*ch +: CH_W] = mag[CH_W-1:0];
		end
	end

	// Output register
	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic        out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl_last.valid && adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_last.valid && adv) begin
			out_data_q <= res;
			out_last_q <= ctl_last.frame_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

/* rtl/rgbc_line_store.sv */
// Two line memories holding the previous two rows, one write and one read port each.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps
module rgbc_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  rgbc_pkg::pix_t  wr_prev,
	input  rgbc_pkg::pix_t  wr_second,
	output rgbc_pkg::pix_t  rd_prev,
	output rgbc_pkg::pix_t  rd_second
);
	import rgbc_pkg::*;

	pix_t prev_mem [DEPTH];
	pix_t second_mem [DEPTH];
	pix_t rd_prev_q;
	pix_t rd_second_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_mem[wr_addr]   <= wr_prev;
			second_mem[wr_addr] <= wr_second;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_prev_q   <= prev_mem[rd_addr];
			rd_second_q <= second_mem[rd_addr];
		end
	end

	assign rd_prev   = rd_prev_q;
	assign rd_second = rd_second_q;

endmodule

/* rtl/rgbc_tap_cell.sv */
// One tap of the 3x3 kernel: multiply-accumulate on three channels, truncated toward zero.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps
module rgbc_tap_cell #(
	parameter int TAP = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic signed [rgbc_pkg::COEF_W-1:0] coef,
	input  rgbc_pkg::cell_ctl_t           ctl_in,
	input  rgbc_pkg::window_t             win_in,
	input  rgbc_pkg::acc3_t               acc_in,
	output rgbc_pkg::cell_ctl_t           ctl_out,
	output rgbc_pkg::window_t             win_out,
	output rgbc_pkg::acc3_t               acc_out
);
	import rgbc_pkg::*;

	logic      valid_q;
	logic      interior_q;
	logic      frame_end_q;
	window_t   win_q;
	acc3_t     acc_q;
	acc3_t     acc_nx;

	// acc = (acc*8 + p*k) / 8 with truncation toward zero
	always_comb begin
		logic signed [SUM_W-1:0] t;
		logic signed [SUM_W-1:0] q;
		logic signed [CH_W:0]    p;
		for (int ch = 0; ch < 3; ch++) begin
			p = signed'({1'b0, win_in[TAP][CH_W*ch +: CH_W]});
			t = SUM_W'(signed'({signed'(acc_in[ch]), 3'b000}))
				+ SUM_W'(p * coef);
			q = t >>> 3;
			if (t[SUM_W-1] && (t[2:0] != 3'b000))
				q = q + SUM_W'(1);
			acc_nx[ch] = q[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			interior_q  <= ctl_in.interior;
			frame_end_q <= ctl_in.frame_end;
			win_q       <= win_in;
			acc_q       <= acc_nx;
		end
	end

	assign ctl_out = '{valid: valid_q, interior: interior_q, frame_end: frame_end_q};
	assign win_out = win_q;
	assign acc_out = acc_q;

endmodule

/* rtl/rgbc_checker.sv */
// Port-level checks for the convolution core, bound to the top level.
// Depends on assert_macros.svh and rgb_3x3_convolution_abs_clamp_core.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result holds
	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Input only backs off when a result is stuck at the output
	`CHK_IMPLY(a_ready_cause, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

	// Last pixel of a frame is a corner, so its result is zero
	`CHK_IMPLY(a_last_zero, m_tvalid && m_tlast, m_tdata == 24'd0, "frame end result not zero")

endmodule

bind rgb_3x3_convolution_abs_clamp_core rgbc_checker u_rgbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);

/* dv/rgb_3x3_convolution_abs_clamp_core_checker.sv */
// Checker for the RGB 3x3 convolution core: watches the configuration port and both
// stream channels, predicts each result and compares it. Depends on rgbc_pkg.
`timescale 1ns / 1ps
module rgb_3x3_convolution_abs_clamp_core_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [23:0]                 s_tdata,   // red_in, green_in, blue_in
	input  logic [0:0]                  s_tuser,   // action
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [23:0]                 m_tdata,   // red_out, green_out, blue_out
	input  logic                        m_tlast,
	input  logic                        cfg_wr_en,
	input  logic [rgbc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [23:0]                 cfg_data,
	output int                          outstanding,
	output int                          mismatches
);
	import rgbc_pkg::*;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       frame_end;
	} filtered_t;

	// Shadow configuration
	logic [10:0] width_reg;
	logic [15:0] height_reg;
	logic [2:0][23:0] kernel_reg;

	// Shadow state
	pix_t line_above [MAX_WIDTH];
	pix_t line_above2 [MAX_WIDTH];
	pix_t win [TAPS];
	int unsigned in_col, in_row, out_col, out_row, backlog;

	filtered_t filtered_q[$];

	function automatic int unsigned eff_w();
		if (width_reg < 11'd1) return 1;
		if (32'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_h();
		return (height_reg < 16'd1) ? 1 : 32'(height_reg);
	endfunction

	// Running sum truncated toward zero after every tap, then |sum| clamped
	function automatic logic [7:0] filter_channel(int sh);
		int acc;
		int px;
		int k;
		acc = 0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				px = 32'((win[r*3+c] >> sh) & 24'hFF);
				k = 32'($signed(kernel_reg[r][8*c +: 8]));
				acc = (acc * 8 + px * k) / 8;
			end
		if (acc < 0) acc = -acc;
		return (acc > 32'(CLAMP_MAX)) ? CLAMP_MAX : acc[7:0];
	endfunction

	function automatic void step_pos(ref int unsigned col, ref int unsigned row);
		if (col + 1 >= eff_w()) begin
			col = 0;
			row = (row + 1 >= eff_h()) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	function automatic void emit_result();
		filtered_t f;
		logic interior;
		interior = out_row > 0 && out_row + 1 < eff_h() && out_col > 0 && out_col + 1 < eff_w();
		f.red = interior ? filter_channel(0) : 8'd0;
		f.green = interior ? filter_channel(8) : 8'd0;
		f.blue = interior ? filter_channel(16) : 8'd0;
		f.frame_end = (out_row + 1 >= eff_h()) && (out_col + 1 >= eff_w());
		step_pos(out_col, out_row);
		if (backlog > 0) backlog--;
		filtered_q.push_back(f);
	endfunction

	function automatic void take_item(logic flush, pix_t px);
		pix_t top, mid;
		if (flush) begin
			if (backlog > 0 && in_row == 0 && in_col == 0) emit_result();
			return;
		end
		top = line_above2[in_col];
		mid = line_above[in_col];
		line_above2[in_col] = mid;
		line_above[in_col] = px;
		for (int r = 0; r < 3; r++) begin
			win[r*3] = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		step_pos(in_col, in_row);
		backlog++;
		if (backlog > eff_w() + 1) emit_result();
	endfunction

	// Predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		filtered_t want;
		if (!arst_n) begin
			width_reg = 11'd3;
			height_reg = 16'd3;
			kernel_reg = '0;
			for (int i = 0; i < TAPS; i++) win[i] = '0;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				line_above[i] = '0;
				line_above2[i] = '0;
			end
			in_col = 0; in_row = 0; out_col = 0; out_row = 0; backlog = 0;
			filtered_q.delete();
			mismatches = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_reg = cfg_data[10:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[15:0];
					REG_KERNEL_TOP:   kernel_reg[0] = cfg_data;
					REG_KERNEL_MID:   kernel_reg[1] = cfg_data;
					REG_KERNEL_BOT:   kernel_reg[2] = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) take_item(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) begin
				if (filtered_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result rgb=%h last=%b", $realtime,
							m_tdata, m_tlast);
				end else begin
					want = filtered_q.pop_front();
					if (m_tdata !== {want.blue, want.green, want.red} ||
						m_tlast !== want.frame_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch exp rgb=%h last=%b got rgb=%h last=%b",
								$realtime, {want.blue, want.green, want.red}, want.frame_end,
								m_tdata, m_tlast);
					end
				end
			end
		end
		outstanding = filtered_q.size();
	end

endmodule

/* dv/rgb_3x3_convolution_abs_clamp_core_tb.sv */
// Testbench top for the RGB 3x3 convolution core: clock, reset, stimulus and verdict.
// Depends on rgbc_pkg, the core and rgb_3x3_convolution_abs_clamp_core_checker.
`timescale 1ns / 1ps
module rgb_3x3_convolution_abs_clamp_core_tb;
	import rgbc_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   DRAIN_CYCLES = 30;
	localparam int   RANDOM_ITEMS = 480;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;   // red_in, green_in, blue_in
	logic [0:0]  s_tuser = '0;   // action
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;        // red_out, green_out, blue_out
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	int outstanding, mismatches;
	int cycles = 0;
	int items_sent = 0;
	logic steady = 1'b0;      // no idling on either side
	logic hold_req = 1'b0;    // ask the receiver for one long hold-off
	logic hold_taken = 1'b0;
	int hold_cnt = 0;
	int unsigned cur_w, cur_h;

	always #2 clk = ~clk;

	rgb_3x3_convolution_abs_clamp_core i_dut (.*);

	rgb_3x3_convolution_abs_clamp_core_checker i_checker (.*);

	// Receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 34);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL rgb_3x3_convolution_abs_clamp_core");
			$finish;
		end
	end

	task automatic send(logic act, logic [23:0] px);
		while (!steady && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] rand_coef();
		if ($urandom_range(1)) return 8'($urandom_range(255));
		return 8'($signed($urandom_range(16)) - 8);
	endfunction

	// Wait for every expected result, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [23:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(logic [10:0] w, logic [15:0] h,
		logic [23:0] ktop, logic [23:0] kmid, logic [23:0] kbot);
		write_reg(REG_IMAGE_WIDTH, 24'(w));
		write_reg(REG_IMAGE_HEIGHT, 24'(h));
		write_reg(REG_KERNEL_TOP, ktop);
		write_reg(REG_KERNEL_MID, kmid);
		write_reg(REG_KERNEL_BOT, kbot);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cur_w = (w < 1) ? 1 : (w > 1024 ? 1024 : w);
		cur_h = (h < 1) ? 1 : h;
	endtask

	function automatic logic [23:0] rand_krow();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	// One frame of pixels; stray flushes mid-frame must be ignored
	task automatic send_frame();
		for (int i = 0; i < cur_w * cur_h; i++) begin
			send(ACT_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
			if (i + 1 < cur_w * cur_h && $urandom_range(19) == 0)
				send(ACT_FLUSH, 24'($urandom));
		end
	endtask

	task automatic flush_all();
		for (int i = 0; i < cur_w + 1 + $urandom_range(2); i++)
			send(ACT_FLUSH, 24'($urandom));
	endtask

	task automatic run_phase(logic [10:0] w, logic [15:0] h, int frames);
		wait_idle();
		configure(w, h, rand_krow(), rand_krow(), rand_krow());
		for (int f = 0; f < frames; f++) begin
			send_frame();
			if ($urandom_range(1)) flush_all();
		end
		flush_all();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset settings (zero kernel), stray flush, drain
		send(ACT_FLUSH, 24'hFFFFFF);
		for (int i = 0; i < 9; i++)
			send(ACT_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
		flush_all();

		// Directed: extreme coefficients on extreme pixels, ignored register index
		wait_idle();
		write_reg(REG_UNUSED, 24'hFFFFFF);
		configure(11'd3, 16'd3, 24'h7F807F, 24'h80017F, 24'hFF7F80);
		for (int i = 0; i < 9; i++)
			send(ACT_PIXEL, (i == 4) ? 24'hFFFFFF : 24'h00FF00);
		flush_all();
		flush_all();   // nothing pending any more

		// Zero register values clamp to one
		run_phase(11'd0, 16'd0, 3);

		// Full-rate stretch with a long receiver hold-off
		wait_idle();
		steady = 1'b1;
		configure(11'd8, 16'd6, rand_krow(), rand_krow(), rand_krow());
		hold_req <= 1'b1;
		send_frame();
		flush_all();
		steady = 1'b0;

		// Random phases, mostly small frames
		while (items_sent < RANDOM_ITEMS)
			run_phase(11'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
				$urandom_range(1, 3));

		// Tallest frame: only a few rows are ever sent
		wait_idle();
		configure(11'd4, 16'd65535, rand_krow(), rand_krow(), rand_krow());
		for (int i = 0; i < 20; i++)
			send(ACT_PIXEL, {rand_chan(), rand_chan(), rand_chan()});

		wait_idle();
		if (mismatches == 0)
			$display("PASS rgb_3x3_convolution_abs_clamp_core");
		else
			$display("FAIL rgb_3x3_convolution_abs_clamp_core");
		$finish;
	end

endmodule
